// ===== sv/drpi_pkg.sv =====
`timescale 1ns / 1ps
package drpi_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] travel_value;
        logic [15:0] gyro_yaw;
        logic        gyro_hold;
        logic [15:0] steering_angle;
        logic [31:0] set_x;
        logic [31:0] set_y;
        logic [15:0] set_heading;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] yaw_rate;
    } out_item_t;

    localparam logic [2:0] REG_TRAVEL_SCALE  = 3'd0;
    localparam logic [2:0] REG_STEP_SCALE    = 3'd1;
    localparam logic [2:0] REG_TICK_RATE     = 3'd2;
    localparam logic [2:0] REG_INV_WHEELBASE = 3'd3;
    localparam logic [2:0] REG_STEER_OFFSET  = 3'd4;
    localparam logic [2:0] REG_SPEED_MODE    = 3'd5;
    localparam logic [2:0] REG_HEAD_SOURCE   = 3'd6;

    localparam logic        OP_TICK     = 1'b0;
    localparam logic        OP_SET_POSE = 1'b1;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]        INV_TWO_PI  = 32'd683565276;

    // arctangent table, Q32 of a turn scaled by 2^32/(2pi)... as binary angle * 2^16
    function automatic logic signed [33:0] atan_lut(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            r = '0;
            case (i)
                4'd0:  r = 34'sd536870912;
                4'd1:  r = 34'sd316933406;
                4'd2:  r = 34'sd167458907;
                4'd3:  r = 34'sd85004756;
                4'd4:  r = 34'sd42667331;
                4'd5:  r = 34'sd21354465;
                4'd6:  r = 34'sd10679838;
                4'd7:  r = 34'sd5340245;
                4'd8:  r = 34'sd2670163;
                4'd9:  r = 34'sd1335087;
                4'd10: r = 34'sd667544;
                4'd11: r = 34'sd333772;
                4'd12: r = 34'sd166886;
                4'd13: r = 34'sd83443;
                4'd14: r = 34'sd41722;
                default: r = 34'sd20861;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/drpi_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle; result in Q1.30.
module drpi_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         angle,
    output logic                done,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out
);

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [3:0]         step_reg;
    logic               busy_reg, flip_reg, done_reg;
    logic signed [33:0] z0, zf;
    logic               need_flip;

    // fold angles beyond a quarter turn
    always_comb
    begin
        z0 = {{2{angle[15]}}, angle, 16'h0};
        need_flip = (z0 > 34'sd1073741824) || (z0 < -34'sd1073741824);
        zf = {{2{~angle[15]}}, ~angle[15], angle[14:0], 16'h0};
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (!z_reg[33])
        begin
            x_next = x_reg - (y_reg >>> step_reg);
            y_next = y_reg + (x_reg >>> step_reg);
            z_next = z_reg - drpi_pkg::atan_lut(step_reg);
        end
        else
        begin
            x_next = x_reg + (y_reg >>> step_reg);
            y_next = y_reg - (x_reg >>> step_reg);
            z_next = z_reg + drpi_pkg::atan_lut(step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= drpi_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            flip_reg <= need_flip;
            z_reg    <= need_flip ? {{2{zf[31]}}, zf[31:0]} : z0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

// ===== sv/drpi_muldiv.sv =====
`timescale 1ns / 1ps
// Shared shift-add multiplier (2 bits per cycle) and restoring divider (1 bit per cycle).
// Multiply: prod = a * b, a signed 48 bits, b unsigned 32 bits.
// Divide: quot = trunc(num / den), signed, num up to 48 bits, den 34 bits.
module drpi_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start_mul,
    input  logic                start_div,
    input  logic signed [47:0]  a,
    input  logic [31:0]         b,
    input  logic signed [47:0]  num,
    input  logic signed [33:0]  den,
    output logic                done,
    output logic signed [79:0]  prod,
    output logic signed [47:0]  quot
);

    logic signed [79:0] acc_reg;
    logic signed [79:0] mcand_reg;
    logic [31:0]        mplr_reg;
    logic [47:0]        dq_reg;
    logic [33:0]        rem_reg;
    logic [33:0]        dabs_reg;
    logic               neg_reg, is_div_reg, busy_reg, done_reg;
    logic [5:0]         cnt_reg;
    logic signed [79:0] pp;
    logic [34:0]        trial;
    logic [47:0]        nabs;

    always_comb
    begin
        pp = '0;
        case (mplr_reg[1:0])
            2'd1: pp = mcand_reg;
            2'd2: pp = mcand_reg <<< 1;
            2'd3: pp = mcand_reg + (mcand_reg <<< 1);
            default: pp = '0;
        endcase
        trial = {rem_reg, dq_reg[47]} - {1'b0, dabs_reg};
        nabs  = num[47] ? 48'(-num) : 48'(num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start_mul || start_div)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= start_div ? 6'd47 : 6'd15;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_mul)
        begin
            is_div_reg <= 1'b0;
            acc_reg    <= '0;
            mcand_reg  <= 80'(a);
            mplr_reg   <= b;
        end
        else if (start_div)
        begin
            is_div_reg <= 1'b1;
            neg_reg    <= num[47] ^ den[33];
            dq_reg     <= nabs;
            rem_reg    <= '0;
            dabs_reg   <= den[33] ? 34'(-den) : 34'(den);
        end
        else if (busy_reg)
        begin
            if (!is_div_reg)
            begin
                acc_reg   <= acc_reg + pp;
                mcand_reg <= mcand_reg <<< 2;
                mplr_reg  <= mplr_reg >> 2;
            end
            else if (!trial[34])
            begin
                rem_reg <= trial[33:0];
                dq_reg  <= {dq_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[32:0], dq_reg[47]};
                dq_reg  <= {dq_reg[46:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quot = neg_reg ? 48'(-dq_reg) : 48'(dq_reg);

endmodule

// ===== sv/dead_reckoning_pose_integrator_unit.sv =====
`timescale 1ns / 1ps
// Dead-reckoning pose integrator. A tick beat advances x, y and heading from travel and
// either gyro yaw difference or a bicycle steering model; a set_pose beat loads the pose.
// One item at a time; a bicycle tick skips the divider when the steering cosine is exactly
// zero. The time is set by the shared 2-bit-per-cycle multiplier, the 16-step CORDIC
// and the 48-step divider.
// A finished result waits in an output register; the next item is taken once that result
// leaves, in the same cycle at the earliest.
module dead_reckoning_pose_integrator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  drpi_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output drpi_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DMUL  = 12'b000000000010,
        S_TRIG  = 12'b000000000100,
        S_VX    = 12'b000000001000,
        S_VY    = 12'b000000010000,
        S_PX    = 12'b000000100000,
        S_PY    = 12'b000001000000,
        S_STRIG = 12'b000010000000,
        S_TDIV  = 12'b000100000000,
        S_PMUL  = 12'b001000000000,
        S_RMUL  = 12'b010000000000,
        S_CMUL  = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic   go_reg;

    logic [31:0] travel_scale_reg, inv_wheelbase_reg;
    logic [15:0] step_scale_reg, steer_offset_reg;
    logic [9:0]  tick_rate_reg;
    logic        speed_mode_reg, head_source_reg;

    logic signed [31:0] x_reg, y_reg;
    logic [15:0]        head_reg, prev_gyro_reg, change_reg;
    drpi_pkg::in_item_t item_reg;
    drpi_pkg::out_item_t res_reg;
    logic               res_valid_reg;
    logic               res_load;

    logic signed [31:0] d_reg, vx_reg, vy_reg, tan_reg, p_reg;
    logic signed [47:0] r_reg;
    logic signed [33:0] c_reg, s_reg;

    logic               cor_start, cor_done;
    logic [15:0]        cor_angle;
    logic signed [33:0] cor_c, cor_s;
    logic               mul_start, div_start, md_done;
    logic signed [47:0] mul_a, div_num;
    logic [31:0]        mul_b;
    logic signed [79:0] prod;
    logic signed [47:0] quot;
    logic signed [47:0] travel_t;

    function automatic logic signed [31:0] sat(input logic signed [79:0] v);
        logic signed [31:0] r;
        begin
            r = v[31:0];
            if (v > 80'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -80'sd2147483648)
                r = 32'sh80000000;
            return r;
        end
    endfunction

    drpi_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_angle),
        .done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
    );

    drpi_muldiv u_muldiv (
        .clk(clk), .rst_n(rst_n), .start_mul(mul_start), .start_div(div_start),
        .a(mul_a), .b(mul_b), .num(div_num), .den(c_reg),
        .done(md_done), .prod(prod), .quot(quot)
    );

    // travel in Q16.16; encoder count halves toward zero
    always_comb
    begin
        if (speed_mode_reg)
            travel_t = 48'(signed'(item_reg.travel_value));
        else
            travel_t = 48'(signed'(item_reg.travel_value) / 2) <<< 16;
    end

    assign in_ready = (state_reg == S_IDLE) && !go_reg && (!res_valid_reg || out_ready);
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // a result is written into the output register at this edge
    assign res_load = ((state_reg == S_IDLE) && in_valid && in_ready
                       && (in_data.operation == drpi_pkg::OP_SET_POSE))
                   || ((state_reg == S_CMUL) && (!head_source_reg || md_done));

    // unit launch control; a start pulses on the cycle a state is entered with go_reg set
    always_comb
    begin
        cor_start = 1'b0;
        cor_angle = head_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = 48'(s_reg) <<< 16;
        unique case (state_reg)
            S_DMUL:
            begin
                mul_start = go_reg;
                mul_a = travel_t;
                mul_b = travel_scale_reg;
            end
            S_TRIG:  cor_start = go_reg;
            S_VX:
            begin
                mul_start = go_reg;
                mul_a = 48'(d_reg);
                mul_b = c_reg[31:0];
            end
            S_VY:
            begin
                mul_start = go_reg;
                mul_a = 48'(d_reg);
                mul_b = s_reg[31:0];
            end
            S_PX:
            begin
                mul_start = go_reg;
                mul_a = 48'(vx_reg);
                mul_b = {16'h0, step_scale_reg};
            end
            S_PY:
            begin
                mul_start = go_reg;
                mul_a = 48'(vy_reg);
                mul_b = {16'h0, step_scale_reg};
            end
            S_STRIG:
            begin
                cor_start = go_reg;
                cor_angle = item_reg.steering_angle + steer_offset_reg;
            end
            S_TDIV:  div_start = go_reg && (c_reg != '0);
            S_PMUL:
            begin
                mul_start = go_reg;
                mul_a = 48'(d_reg);
                mul_b = inv_wheelbase_reg;
            end
            S_RMUL:
            begin
                mul_start = go_reg;
                mul_a = 48'(p_reg);
                mul_b = tan_reg;
            end
            S_CMUL:
            begin
                mul_start = go_reg;
                mul_a = r_reg;
                mul_b = drpi_pkg::INV_TWO_PI;
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_scale_reg  <= 32'd16777216;
            step_scale_reg    <= 16'd3277;
            tick_rate_reg     <= 10'd20;
            inv_wheelbase_reg <= 32'd65536;
            steer_offset_reg  <= '0;
            speed_mode_reg    <= 1'b0;
            head_source_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                drpi_pkg::REG_TRAVEL_SCALE:  travel_scale_reg  <= cfg_data;
                drpi_pkg::REG_STEP_SCALE:    step_scale_reg    <= cfg_data[15:0];
                drpi_pkg::REG_TICK_RATE:     tick_rate_reg     <= cfg_data[9:0];
                drpi_pkg::REG_INV_WHEELBASE: inv_wheelbase_reg <= {8'h0, cfg_data[23:0]};
                drpi_pkg::REG_STEER_OFFSET:  steer_offset_reg  <= cfg_data[15:0];
                drpi_pkg::REG_SPEED_MODE:    speed_mode_reg    <= cfg_data[0];
                drpi_pkg::REG_HEAD_SOURCE:   head_source_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            head_reg      <= '0;
            prev_gyro_reg <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && out_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        if (in_data.operation == drpi_pkg::OP_SET_POSE)
                        begin
                            x_reg    <= in_data.set_x;
                            y_reg    <= in_data.set_y;
                            head_reg <= in_data.set_heading;
                            res_reg  <= '{pos_x: in_data.set_x, pos_y: in_data.set_y,
                                          heading: in_data.set_heading,
                                          vel_x: '0, vel_y: '0, yaw_rate: '0};
                        end
                        else
                        begin
                            state_reg <= S_DMUL;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                S_DMUL: if (md_done)
                begin
                    d_reg     <= sat(prod >>> 24);
                    state_reg <= S_TRIG;
                    go_reg    <= 1'b1;
                end
                S_TRIG: if (cor_done)
                begin
                    c_reg     <= cor_c;
                    s_reg     <= cor_s;
                    state_reg <= S_VX;
                    go_reg    <= 1'b1;
                end
                S_VX: if (md_done)
                begin
                    // cos is signed; correct unsigned multiplier view
                    vx_reg    <= sat((prod - (c_reg[33] ? (80'(d_reg) <<< 32) : 80'sd0))
                                     >>> 30);
                    state_reg <= S_VY;
                    go_reg    <= 1'b1;
                end
                S_VY: if (md_done)
                begin
                    vy_reg    <= sat((prod - (s_reg[33] ? (80'(d_reg) <<< 32) : 80'sd0))
                                     >>> 30);
                    state_reg <= S_PX;
                    go_reg    <= 1'b1;
                end
                S_PX: if (md_done)
                begin
                    x_reg     <= sat(80'(x_reg) + (prod >>> 16));
                    state_reg <= S_PY;
                    go_reg    <= 1'b1;
                end
                S_PY: if (md_done)
                begin
                    y_reg <= sat(80'(y_reg) + (prod >>> 16));
                    if (head_source_reg)
                    begin
                        state_reg <= S_STRIG;
                        go_reg    <= 1'b1;
                    end
                    else
                    begin
                        change_reg <= item_reg.gyro_hold ? 16'h0
                                    : item_reg.gyro_yaw - prev_gyro_reg;
                        state_reg  <= S_CMUL;
                    end
                end
                S_STRIG: if (cor_done)
                begin
                    c_reg     <= cor_c;
                    s_reg     <= cor_s;
                    state_reg <= S_TDIV;
                    go_reg    <= 1'b1;
                end
                S_TDIV:
                begin
                    if (c_reg == '0)
                    begin
                        tan_reg   <= s_reg[33] ? 32'sh80000000 : 32'sh7fffffff;
                        state_reg <= S_PMUL;
                        go_reg    <= 1'b1;
                    end
                    else if (md_done)
                    begin
                        tan_reg   <= sat(80'(quot));
                        state_reg <= S_PMUL;
                        go_reg    <= 1'b1;
                    end
                end
                S_PMUL: if (md_done)
                begin
                    p_reg     <= sat(prod >>> 16);
                    state_reg <= S_RMUL;
                    go_reg    <= 1'b1;
                end
                S_RMUL: if (md_done)
                begin
                    r_reg     <= 48'((prod - (tan_reg[31] ? (80'(p_reg) <<< 32) : 80'sd0))
                                     >>> 16);
                    state_reg <= S_CMUL;
                    go_reg    <= 1'b1;
                end
                S_CMUL:
                begin
                    // gyro path arrives without go; finish at once
                    if (!head_source_reg || md_done)
                    begin
                        logic [15:0] chg;
                        chg = head_source_reg ? 16'(prod >>> 32) : change_reg;
                        head_reg      <= head_reg + chg;
                        prev_gyro_reg <= item_reg.gyro_yaw;
                        res_reg <= '{pos_x: x_reg, pos_y: y_reg, heading: head_reg + chg,
                                     vel_x: vx_reg, vel_y: vy_reg,
                                     yaw_rate: 32'(signed'(chg) * signed'({1'b0, tick_rate_reg}))};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while busy");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");

endmodule

// ===== test/tb_dead_reckoning_pose_integrator_unit.sv =====
`timescale 1ns / 1ps
module tb_dead_reckoning_pose_integrator_unit;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    drpi_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    drpi_pkg::out_item_t out_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = drpi_pkg::REG_TRAVEL_SCALE;
    logic [31:0]         cfg_data = '0;

    dead_reckoning_pose_integrator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // predictor copy of registers and pose
    logic [31:0] k_travel_scale;
    logic [15:0] k_step_scale;
    logic [9:0]  k_tick_rate;
    logic [23:0] k_inv_wb;
    logic [15:0] k_steer_off;
    logic        k_speed_mode;
    logic        k_head_src;
    logic signed [31:0] p_x, p_y;
    logic [15:0] p_head, p_gyro;

    drpi_pkg::out_item_t pose_queue[$];
    int        errors = 0;
    int        out_stall_mode = 0;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // floor(a*b/2^s), split so the product stays inside 64 bits
    function automatic longint scaled_mul(longint a, logic [31:0] b, int s);
        longint hi, lo, q;
        hi = longint'(b[31:16]);
        lo = longint'(b[15:0]);
        q = floor_shift(a * lo, 16);
        return floor_shift(a * hi + q, s - 16);
    endfunction

    // 16-step CORDIC, Q1.30 cos/sin of a binary angle
    task automatic cordic_trig(input logic [15:0] ang, output longint c, output longint s);
        longint z, x, y, nx, ny;
        logic [31:0] z32;
        bit flip;
        z32 = {ang, 16'h0};
        z = longint'($signed(z32));
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824)
        begin
            z32 = z32 + 32'h8000_0000;
            z = longint'($signed(z32));
            flip = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - longint'(drpi_pkg::atan_lut(i[3:0]));
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + longint'(drpi_pkg::atan_lut(i[3:0]));
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_pose(input drpi_pkg::in_item_t it, output drpi_pkg::out_item_t r);
        longint tv, t, d, c, s, vx, vy, sc, ss, tn, p, rr, rate, delta;
        logic [15:0] change, a;
        vx = 0;
        vy = 0;
        rate = 0;
        if (it.operation == drpi_pkg::OP_SET_POSE)
        begin
            p_x = it.set_x;
            p_y = it.set_y;
            p_head = it.set_heading;
        end
        else
        begin
            tv = longint'($signed(it.travel_value));
            t = k_speed_mode ? tv : (tv / 2) * 65536;
            d = clip32(scaled_mul(t, k_travel_scale, 24));
            cordic_trig(p_head, c, s);
            vx = clip32(floor_shift(d * c, 30));
            vy = clip32(floor_shift(d * s, 30));
            if (!k_head_src)
                change = it.gyro_hold ? 16'h0 : it.gyro_yaw - p_gyro;
            else
            begin
                a = it.steering_angle + k_steer_off;
                cordic_trig(a, sc, ss);
                if (sc == 0)
                    tn = (ss >= 0) ? S32_MAX : S32_MIN;
                else
                    tn = clip32((ss * 65536) / sc);
                p = clip32(scaled_mul(d, {8'h0, k_inv_wb}, 16));
                rr = floor_shift(p * tn, 16);
                change = 16'(scaled_mul(rr, drpi_pkg::INV_TWO_PI, 32));
            end
            p_gyro = it.gyro_yaw;
            delta = longint'($signed(change));
            rate = delta * longint'(k_tick_rate);
            p_x = 32'(clip32(longint'(p_x) + floor_shift(vx * longint'(k_step_scale), 16)));
            p_y = 32'(clip32(longint'(p_y) + floor_shift(vy * longint'(k_step_scale), 16)));
            p_head = p_head + change;
        end
        r.pos_x = p_x;
        r.pos_y = p_y;
        r.heading = p_head;
        r.vel_x = 32'(vx);
        r.vel_y = 32'(vy);
        r.yaw_rate = 32'(rate);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            drpi_pkg::REG_TRAVEL_SCALE:  k_travel_scale = v;
            drpi_pkg::REG_STEP_SCALE:    k_step_scale = v[15:0];
            drpi_pkg::REG_TICK_RATE:     k_tick_rate = v[9:0];
            drpi_pkg::REG_INV_WHEELBASE: k_inv_wb = v[23:0];
            drpi_pkg::REG_STEER_OFFSET:  k_steer_off = v[15:0];
            drpi_pkg::REG_SPEED_MODE:    k_speed_mode = v[0];
            default:                     k_head_src = v[0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drive one beat; the expectation is queued at acceptance
    task automatic send_beat(input drpi_pkg::in_item_t it, input bit has_fixed,
                             input drpi_pkg::out_item_t fixed);
        drpi_pkg::out_item_t r;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pose(it, r);
        if (has_fixed && r != fixed)
        begin
            $display("%0t directed row disagrees: table %h predictor %h", $time, fixed, r);
            errors++;
        end
        pose_queue.push_back(r);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic drpi_pkg::in_item_t rand_beat(bit allow_set);
        drpi_pkg::in_item_t it;
        it.operation = allow_set && ($urandom_range(0, 15) == 0) ? drpi_pkg::OP_SET_POSE
                                                                 : drpi_pkg::OP_TICK;
        case ($urandom_range(0, 5))
            0: it.travel_value = $urandom;
            1: it.travel_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: it.travel_value = 32'($signed($urandom_range(0, 4000)) - 2000)
                                       << $urandom_range(0, 12);
        endcase
        it.gyro_yaw = 16'($urandom);
        it.gyro_hold = ($urandom_range(0, 7) == 0);
        it.steering_angle = $urandom_range(0, 3) == 0 ? 16'($urandom)
                            : 16'($signed($urandom_range(0, 8000)) - 4000);
        it.set_x = $urandom;
        it.set_y = $urandom;
        it.set_heading = 16'($urandom);
        return it;
    endfunction

    // result checker with its own stall pattern
    always @(posedge clk)
    begin
        drpi_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_queue.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pose_queue.pop_front();
                if (out_data.pos_x !== want.pos_x)
                    $display("%0t pos_x expected %h actual %h", $time, want.pos_x, out_data.pos_x);
                if (out_data.pos_y !== want.pos_y)
                    $display("%0t pos_y expected %h actual %h", $time, want.pos_y, out_data.pos_y);
                if (out_data.heading !== want.heading)
                    $display("%0t heading expected %h actual %h", $time, want.heading,
                             out_data.heading);
                if (out_data.vel_x !== want.vel_x)
                    $display("%0t vel_x expected %h actual %h", $time, want.vel_x, out_data.vel_x);
                if (out_data.vel_y !== want.vel_y)
                    $display("%0t vel_y expected %h actual %h", $time, want.vel_y, out_data.vel_y);
                if (out_data.yaw_rate !== want.yaw_rate)
                    $display("%0t yaw_rate expected %h actual %h", $time, want.yaw_rate,
                             out_data.yaw_rate);
                if (out_data !== want)
                    errors++;
            end
        end
    end

    always @(negedge clk)
    begin
        case (out_stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
        if ($urandom_range(0, 499) == 0)
            out_stall_mode <= $urandom_range(0, 2);
    end

    // watchdog
    initial
    begin
        #400ms;
        $display("end of test: mismatches");
        $finish;
    end

    typedef struct {
        drpi_pkg::in_item_t  beat;
        bit                  has_fixed;
        drpi_pkg::out_item_t fixed;
    } row_t;

    initial
    begin
        row_t rows[$];
        row_t rw;
        drpi_pkg::in_item_t it;
        int burst;
        k_travel_scale = 32'd16777216;
        k_step_scale = 16'd3277;
        k_tick_rate = 10'd20;
        k_inv_wb = 24'd65536;
        k_steer_off = 16'd0;
        k_speed_mode = 1'b0;
        k_head_src = 1'b0;
        p_x = 0;
        p_y = 0;
        p_head = 0;
        p_gyro = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: zero tick after reset, set_pose extremes, gyro cases
        rw.beat = '0; rw.has_fixed = 1; rw.fixed = '0;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.operation = drpi_pkg::OP_SET_POSE;
        rw.beat.set_x = 32'h7FFF_FFFF; rw.beat.set_y = 32'h8000_0000;
        rw.beat.set_heading = 16'h8000; rw.beat.travel_value = 32'hFFFF_FFFF;
        rw.beat.gyro_yaw = 16'hFFFF; rw.beat.gyro_hold = 1; rw.beat.steering_angle = 16'hFFFF;
        rw.fixed = '0; rw.fixed.pos_x = 32'h7FFF_FFFF; rw.fixed.pos_y = 32'h8000_0000;
        rw.fixed.heading = 16'h8000;
        rows.push_back(rw);
        rw.has_fixed = 0;
        rw.beat = '0; rw.beat.travel_value = 32'h7FFF_FFFF; rw.beat.gyro_yaw = 16'h7FFF;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.travel_value = 32'h8000_0000; rw.beat.gyro_yaw = 16'h8000;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.travel_value = 32'd1; rw.beat.gyro_yaw = 16'h1234;
        rw.beat.gyro_hold = 1;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.travel_value = -32'sd3; rw.beat.gyro_yaw = 16'h0100;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.operation = drpi_pkg::OP_SET_POSE; rw.beat.set_heading = 16'h4000;
        rows.push_back(rw);
        rw.beat = '0; rw.beat.travel_value = 32'd2000; rw.beat.gyro_yaw = 16'h0100;
        rows.push_back(rw);
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
        drain_and_settle();

        // bicycle model: steering at and near a quarter turn, half-turn offset, scale extremes
        write_reg(drpi_pkg::REG_HEAD_SOURCE, 32'd1);
        write_reg(drpi_pkg::REG_SPEED_MODE, 32'd1);
        write_reg(drpi_pkg::REG_STEER_OFFSET, 32'h0000_8000);
        write_reg(drpi_pkg::REG_INV_WHEELBASE, 32'h00FF_FFFF);
        write_reg(drpi_pkg::REG_TRAVEL_SCALE, 32'hFFFF_FFFF);
        write_reg(drpi_pkg::REG_STEP_SCALE, 32'h0000_FFFF);
        write_reg(drpi_pkg::REG_TICK_RATE, 32'd1000);
        foreach (rows[i])
        begin
            it = rows[i].beat;
            it.steering_angle = 16'h4000 + 16'(i);
            send_beat(it, 0, '0);
        end
        it = '0; it.travel_value = 32'h0001_0000; it.steering_angle = 16'hC000;
        send_beat(it, 0, '0);
        drain_and_settle();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_reg(drpi_pkg::REG_TICK_RATE, 32'd0);
                1: write_reg(drpi_pkg::REG_TRAVEL_SCALE, 32'd0);
                2: write_reg(drpi_pkg::REG_STEER_OFFSET, 32'h0000_7FFF);
                3: write_reg(drpi_pkg::REG_INV_WHEELBASE, 32'd0);
                4: write_reg(drpi_pkg::REG_STEP_SCALE, 32'd0);
                default: ;
            endcase
            write_reg(drpi_pkg::REG_HEAD_SOURCE, $urandom_range(0, 1));
            write_reg(drpi_pkg::REG_SPEED_MODE, $urandom_range(0, 1));
            write_reg(drpi_pkg::REG_TRAVEL_SCALE, $urandom_range(0, 1) ? $urandom
                                        : $urandom_range(1 << 20, 1 << 25));
            write_reg(drpi_pkg::REG_STEP_SCALE, $urandom_range(0, 65535));
            write_reg(drpi_pkg::REG_TICK_RATE, $urandom_range(1, 1000));
            write_reg(drpi_pkg::REG_INV_WHEELBASE, $urandom_range(0, 24'hFF_FFFF));
            write_reg(drpi_pkg::REG_STEER_OFFSET, $urandom);
            for (int n = 0; n < 140; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 140; b++, n++)
                    send_beat(rand_beat(1), 0, '0);
                if ($urandom_range(0, 1))
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(negedge clk);
                end
            end
            drain_and_settle();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
